/* hw/rtl/olfb_pkg.sv */
// Shared types and constants for the ordered list block.
package olfb_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_END    = 2'd0,
    ACT_FRONT  = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_FROM_LEFT,
    CMD_FROM_RIGHT,
    CMD_FROM_HEAD,
    CMD_DELETE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      valid;
  } cell_ctrl_t;

endpackage

/* hw/rtl/olfb_cell.sv */
// One list cell: holds an entry, compares it and moves it along the chain.
module olfb_cell (
  input  logic                      clk,
  input  olfb_pkg::cell_ctrl_t      ctrl,
  input  logic [olfb_pkg::VAL_W-1:0] new_val,
  input  logic [olfb_pkg::VAL_W-1:0] left_val,
  input  logic [olfb_pkg::VAL_W-1:0] right_val,
  input  logic [olfb_pkg::VAL_W-1:0] head_val,
  input  logic                      found_in,
  output logic                      found_out,
  output logic [olfb_pkg::VAL_W-1:0] val
);
  import olfb_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // first match at or ahead of this cell pulls the rest of the list forward
  assign found_out = found_in | (ctrl.valid & (val_r == new_val));
  assign val       = val_r;

  always_comb begin
    case (ctrl.cmd)
      CMD_LOAD:       val_nxt = new_val;
      CMD_FROM_LEFT:  val_nxt = left_val;
      CMD_FROM_RIGHT: val_nxt = right_val;
      CMD_FROM_HEAD:  val_nxt = head_val;
      CMD_DELETE:     val_nxt = found_out ? right_val : val_r;
      default:        val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* hw/rtl/ordered_list_front_back_delete_top.sv */
// Top level of the ordered list: control sequencer, cell chain and result register.
//
// Keeps an ordered list of up to 16 signed 32-bit entries in a chain of cells.
// Input requests (in_*): in_tuser carries the action (insert at end, insert at
// front, delete first match, list out), in_tdata the value. Results (out_*):
// out_tuser is the status, out_tdata the emitted entry and the entry count,
// out_tlast marks the final result of a request.
// For insert and delete all cells compare and shift at once, and the single
// result appears in the output register on the next cycle.
// List out, once accepted, emits one entry per cycle while the output
// register is free (one result if empty): the chain rotates by one cell
// per result, the head cell feeding the output register and moving to the
// tail, so after N steps the list is back in order. The next request is
// accepted once the final result is registered and the output register is
// free or being drained.
// When the receiver holds out_tready low the output register holds its
// result and the chain pauses; in_tready stays low meanwhile.
// Reset empties the list and clears the output valid flag; entry contents
// need no clearing since only held entries are ever read.
module ordered_list_front_back_delete_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] entry_value, [36:32] entry_count, rest zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last_of_run
);
  import olfb_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  cell_ctrl_t       ctrl [CAPACITY];
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY:0] found_chain;

  action_t          act;
  logic             out_free;
  logic             accept;
  logic             emit;
  logic             full;
  logic             last_step;

  assign act       = action_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign emit      = (state_r == S_LIST) && out_free;
  assign full      = (fill_r == CNT_W'(CAPACITY));
  assign last_step = (cnt_r == fill_r - CNT_W'(1));

  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olfb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .new_val   (in_tdata),
      .left_val  (cell_val[(g == 0) ? 0 : g - 1]),
      .right_val (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .head_val  (cell_val[0]),
      .found_in  (found_chain[g]),
      .found_out (found_chain[g + 1]),
      .val       (cell_val[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && act == ACT_LIST && fill_r != '0) state_nxt = S_LIST;
      end
      S_LIST: begin
        if (emit && last_step) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell commands and result
  always_comb begin
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].valid = (CNT_W'(i) < fill_r);
      ctrl[i].cmd   = CMD_HOLD;
    end

    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_value_nxt  = '0;
      out_last_nxt   = 1'b1;
      cnt_nxt        = '0;
      case (act)
        ACT_END, ACT_FRONT: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (act == ACT_END) begin
                if (CNT_W'(i) == fill_r) ctrl[i].cmd = CMD_LOAD;
              end else begin
                ctrl[i].cmd = (i == 0) ? CMD_LOAD : CMD_FROM_LEFT;
              end
            end
          end
        end
        ACT_DELETE: begin
          for (int i = 0; i < CAPACITY; i++) ctrl[i].cmd = CMD_DELETE;
          if (found_chain[CAPACITY]) begin
            fill_nxt = fill_r - CNT_W'(1);
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          // list out: empty list answers at once, else the sequencer streams
          if (fill_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
          end
        end
      endcase
      out_count_nxt = fill_nxt;
    end else if (emit) begin
      // hand the head to the output, rotate the held entries by one
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_DONE;
      out_value_nxt  = cell_val[0];
      out_last_nxt   = last_step;
      out_count_nxt  = fill_r;
      cnt_nxt        = cnt_r + CNT_W'(1);
      for (int i = 0; i < CAPACITY; i++) begin
        ctrl[i].cmd = (CNT_W'(i) == fill_r - CNT_W'(1)) ? CMD_FROM_HEAD : CMD_FROM_RIGHT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(40 - VAL_W - CNT_W){1'b0}}, out_count_r, out_value_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (act == ACT_END || act == ACT_FRONT) && full)
      |=> (out_tvalid && out_tuser == ST_FULL && fill_r == CNT_W'(CAPACITY)))
    else $error("insert into full list not refused");

  a_list_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (cnt_r < fill_r))
    else $error("list out step beyond held entries");

  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_step) |=> (out_tvalid && out_tlast && state_r == S_IDLE))
    else $error("list out did not close with last result");

endmodule

/* tb/olfb_checker.sv */
// Checker for the ordered list: tracks the held entries and compares every result.
`timescale 1ns / 100ps
module olfb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] entry_value, [36:32] entry_count
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        out_tlast,
  output int          mismatches,
  output int          results_left
);
  import olfb_pkg::*;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic             last;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic [VAL_W-1:0] held_entries[$];
  list_result_t     due_results[$];

  initial begin
    mismatches   = 0;
    results_left = 0;
  end

  task automatic queue_result(status_t st, logic [VAL_W-1:0] val, logic last);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.last   = last;
    r.count  = CNT_W'(held_entries.size());
    due_results.push_back(r);
  endtask

  // Apply one accepted request to the held list and queue what it must produce.
  task automatic apply_list_action(action_t act, logic [VAL_W-1:0] val);
    int hit;
    hit = -1;
    case (act)
      ACT_END, ACT_FRONT: begin
        if (held_entries.size() >= CAPACITY) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (act == ACT_END) held_entries.push_back(val);
          else held_entries.push_front(val);
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        for (int i = 0; i < held_entries.size(); i++) begin
          if (hit < 0 && held_entries[i] == val) hit = i;
        end
        if (hit < 0) begin
          queue_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          held_entries.delete(hit);
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      default: begin
        if (held_entries.size() == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (held_entries[i])
            queue_result(ST_DONE, held_entries[i], i == held_entries.size() - 1);
        end
      end
    endcase
  endtask

  task automatic compare_result();
    list_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing due: status %0d value %h last %0d count %0d",
                 $time, out_tuser, out_tdata[31:0], out_tlast, out_tdata[36:32]);
    end else begin
      want = due_results.pop_front();
      if (out_tuser != want.status || out_tdata[31:0] != want.value ||
          out_tlast != want.last || out_tdata[36:32] != want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch: expected status %0d value %h last %0d count %0d, %s",
                   $time, want.status, want.value, want.last, want.count,
                   $sformatf("got status %0d value %h last %0d count %0d",
                             out_tuser, out_tdata[31:0], out_tlast, out_tdata[36:32]));
      end
    end
  endtask

  // Results drain before new requests are predicted; a result never belongs
  // to a request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      held_entries.delete();
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) compare_result();
      if (in_tvalid && in_tready) apply_list_action(action_t'(in_tuser), in_tdata);
    end
    results_left <= due_results.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the ordered list testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import olfb_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = ACT_LIST;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          mismatches;
  int          results_left;

  // calm: no idling for a stretch; quiet: no idling until the end
  bit          calm  = 1'b0;
  bit          quiet = 1'b0;
  logic [31:0] value_pool[8];

  ordered_list_front_back_delete_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  olfb_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .results_left (results_left)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("ordered_list_front_back_delete_top verification failed");
    $finish;
  end

  // Receiver: stall in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Hold the request until accepted, then maybe idle for a burst.
  task automatic send_request(action_t act, logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
  endtask

  // Mostly reuse a small set of values so deletes find matches and duplicates.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return value_pool[$urandom_range(0, 7)];
    if (roll == 7) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    logic [31:0] fill_vals[16];
    int          roll;
    bit          filling;
    action_t     act;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, full list, duplicates.
    send_request(ACT_LIST, 32'hFFFF_FFFF);
    send_request(ACT_DELETE, 32'h0000_0001);
    fill_vals[0] = 32'h7FFF_FFFF;
    fill_vals[1] = 32'h8000_0000;
    fill_vals[2] = 32'h0000_0000;
    fill_vals[3] = 32'hFFFF_FFFF;
    fill_vals[4] = 32'h0000_0005;
    fill_vals[5] = 32'h0000_0005;
    for (int i = 6; i < 16; i++) fill_vals[i] = $urandom;
    for (int i = 0; i < 16; i++)
      send_request(i % 2 ? ACT_FRONT : ACT_END, fill_vals[i]);
    send_request(ACT_END, 32'h0000_0042);
    send_request(ACT_FRONT, 32'h0000_0043);
    send_request(ACT_LIST, 32'h0000_0000);
    send_request(ACT_DELETE, 32'h0000_1234);
    send_request(ACT_DELETE, 32'hFFFF_FFFF);
    send_request(ACT_DELETE, 32'h0000_0005);
    send_request(ACT_LIST, 32'h5555_AAAA);
    wait_for_drain();

    // Random: alternate between filling and draining phases.
    filling = 1'b1;
    for (int n = 0; n < 95; n++) begin
      if (n % 40 == 0) begin
        foreach (value_pool[k])
          value_pool[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      end
      if ($urandom_range(0, 19) == 0) filling = !filling;
      if ($urandom_range(0, 24) == 0) calm = !calm;
      if (n == 80) quiet = 1'b1;
      if (n == 48) wait_for_drain();
      roll = $urandom_range(0, 99);
      if (filling)
        act = roll < 35 ? ACT_END : roll < 70 ? ACT_FRONT : roll < 85 ? ACT_DELETE : ACT_LIST;
      else
        act = roll < 12 ? ACT_END : roll < 25 ? ACT_FRONT : roll < 85 ? ACT_DELETE : ACT_LIST;
      send_request(act, act == ACT_LIST ? 32'($urandom) : pick_value());
    end

    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && results_left == 0)
      $display("ordered_list_front_back_delete_top verification clean");
    else
      $display("ordered_list_front_back_delete_top verification failed");
    $finish;
  end

endmodule
